// ----- rtl/core/i2a_pkg.sv -----
package i2a_pkg;

    // width of the value field on the request channel
    localparam int VALUE_W = 32;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A    = 8'h61;
    localparam logic [7:0] CHAR_X    = 8'h78;

    // format selector codes
    localparam logic CMD_HEX = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_PFX0,
        ST_PFXX,
        ST_EMIT
    } state_t;

    // one operation per cycle for the whole row of digit cells
    typedef struct packed {
        logic load;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

    function automatic logic [7:0] ascii_of(input logic [3:0] d);
        logic [7:0] r;
        if (d >= 4'd10)
        begin
            r = CHAR_A + {4'b0000, d} - 8'd10;
        end
        else
        begin
            r = CHAR_ZERO + {4'b0000, d};
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/integer_to_ascii_formatter.sv -----
// integer_to_ascii_formatter: renders an unsigned number as ASCII text
//
// request channel (req_valid / req_stall) carries cmd and value; cmd 0 gives
// "0x" plus lowercase hex digits without leading zeros, cmd 1 gives decimal
// digits without leading zeros ("0" for zero)
// response channel (rsp_valid / rsp_stall) carries one character per
// transaction in char_code, with last set on the final character
// one number is handled at a time: req_stall is high from acceptance until
// the last character has been loaded into the output register
// decimal: a bit-serial double dabble shifts the value bits one by one into a
// row of BCD digit cells, then suppressed leading zero digits are shifted
// out, the skip is left and one character is emitted per remaining digit
// hex: the cells load nibbles directly; skipped zero cells are shifted out,
// the skip is left, then the "0x" prefix and one digit per remaining cell
// a stalled response holds its character; while emitting, the row of cells waits with it
// reset clears the controller and the output valid; the digit cells are
// loaded at each new transaction and need no reset
module integer_to_ascii_formatter #(
    parameter int VALUE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          cmd,
    input  logic [i2a_pkg::VALUE_W-1:0]   value,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [7:0]                    char_code,
    output logic                          last
);
    import i2a_pkg::*;

    // decimal digits needed for VALUE_BITS bits, floor(n*log10(2))+1
    localparam int NCELL = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int NIB   = (VALUE_BITS + 3) / 4;
    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam int REM_W = $clog2(NCELL + 1);

    state_t             state_reg, state_next;
    logic               hex_reg, hex_next;
    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         char_reg, char_next;
    logic               last_reg, last_next;

    logic [VALUE_BITS-1:0] value_ext;
    logic [NIB*4-1:0]      hex_pad;
    cell_ctrl_t            ctrl;
    logic [3:0]            dig [NCELL];
    logic                  cry [NCELL];
    logic                  accept;
    logic                  emit_ok;
    logic [3:0]            top_dig;

    // value masked or zero-extended to the configured width
    generate
        if (VALUE_BITS >= VALUE_W)
        begin : g_wide
            always_comb
            begin
                value_ext = '0;
                value_ext[VALUE_W-1:0] = value;
            end
        end
        else
        begin : g_narrow
            assign value_ext = value[VALUE_BITS-1:0];
        end
    endgenerate

    always_comb
    begin
        hex_pad = '0;
        hex_pad[VALUE_BITS-1:0] = value_ext;
    end

    // row of digit cells, cell 0 is least significant
    generate
        for (genvar j = 0; j < NCELL; j++)
        begin : g_cell
            logic [3:0] ld;
            logic [3:0] pd;
            logic       pc;
            if (j < NIB)
            begin : g_ld
                assign ld = (cmd == CMD_HEX) ? hex_pad[j*4 +: 4] : 4'd0;
            end
            else
            begin : g_ld0
                assign ld = 4'd0;
            end
            if (j == 0)
            begin : g_first
                assign pd = 4'd0;
                assign pc = bin_reg[VALUE_BITS-1];
            end
            else
            begin : g_rest
                assign pd = dig[j-1];
                assign pc = cry[j-1];
            end
            i2a_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .load_digit (ld),
                .prev_digit (pd),
                .prev_carry (pc),
                .digit      (dig[j]),
                .carry      (cry[j])
            );
        end
    endgenerate

    assign top_dig   = dig[NCELL-1];
    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign emit_ok   = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        hex_next       = hex_reg;
        bin_next       = bin_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        ctrl           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load = 1'b1;
                    hex_next  = (cmd == CMD_HEX);
                    bin_next  = value_ext;
                    cnt_next  = CNT_W'(VALUE_BITS - 1);
                    rem_next  = REM_W'(NCELL);
                    state_next = (cmd == CMD_HEX) ? ST_SKIP : ST_CONV;
                end
            end
            ST_CONV:
            begin
                // shift one value bit into the cells per cycle
                ctrl.dabble = 1'b1;
                bin_next    = {bin_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zero digits, keep at least one
                if ((top_dig == 4'd0) && (rem_reg > REM_W'(1)))
                begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = hex_reg ? ST_PFX0 : ST_EMIT;
                end
            end
            ST_PFX0:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_ZERO;
                    last_next      = 1'b0;
                    state_next     = ST_PFXX;
                end
            end
            ST_PFXX:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_X;
                    last_next      = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ascii_of(top_dig);
                    last_next      = (rem_reg == REM_W'(1));
                    ctrl.shift     = 1'b1;
                    rem_next       = rem_reg - 1'b1;
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hex_reg  <= hex_next;
        bin_reg  <= bin_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign rsp_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule

// ----- rtl/core/i2a_cell.sv -----
module i2a_cell (
    input  logic                clk,
    input  i2a_pkg::cell_ctrl_t ctrl,
    input  logic [3:0]          load_digit,
    input  logic [3:0]          prev_digit,
    input  logic                prev_carry,
    output logic [3:0]          digit,
    output logic                carry
);
    import i2a_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // add 3 before the shift so the digit carries at ten
    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    end

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.load)
        begin
            digit_next = load_digit;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[2:0], prev_carry};
        end
        else if (ctrl.shift)
        begin
            digit_next = prev_digit;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;
    assign carry = adj[3];

endmodule
